### hdl/rpg_pkg.sv
// Package with types, codes and helpers shared by the patch growth engine.
`timescale 1ns / 1ps
package rpg_pkg;

  localparam int DEF_MAX_ROWS    = 64;
  localparam int DEF_MAX_COLS    = 64;
  localparam int DEF_WEIGHT_BITS = 16;
  localparam int DIM_W           = 12;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_GATHER = 2'd1;
  localparam logic [1:0] REQ_GROW   = 2'd2;

  localparam logic [1:0] MODE_RANDOM = 2'd0;
  localparam logic [1:0] MODE_CIRC   = 2'd1;
  localparam logic [1:0] MODE_COST   = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_ZERO  = 2'd2;

  localparam logic [1:0] CFG_GROW_MODE    = 2'd0;
  localparam logic [1:0] CFG_CONNECTIVITY = 2'd1;
  localparam logic [1:0] CFG_GRID_ROWS    = 2'd2;
  localparam logic [1:0] CFG_GRID_COLS    = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [5:0]  cell_row;
    logic [5:0]  cell_col;
    logic        patch_bit;
    logic [15:0] cell_weight;
    logic [15:0] random_fraction;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  grown_row;
    logic [5:0]  grown_col;
    logic [12:0] frontier_size;
    logic        regathered;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_PICK_MUL, ST_PICK_SET,
    ST_SUM_L, ST_SUM_W, ST_SUM_A, ST_SUM_DONE, ST_T1, ST_T2,
    ST_CUM_L, ST_CUM_W, ST_CUM_A,
    ST_TAKE, ST_TAKE2, ST_TAKE3,
    ST_NB, ST_NB2, ST_NB3,
    ST_G_SELF, ST_G_SELF2, ST_G_NB, ST_G_NB2,
    ST_OUT
  } state_t;

  // Neighbor offset {dr, dc}, each a 2-bit signed value.
  function automatic logic [3:0] nb_offset(input logic conn8, input logic [2:0] k);
    logic [3:0] o;
    o = 4'b0000;
    if (conn8) begin
      unique case (k)
        3'd0: o = {2'b11, 2'b11};
        3'd1: o = {2'b00, 2'b11};
        3'd2: o = {2'b01, 2'b11};
        3'd3: o = {2'b11, 2'b00};
        3'd4: o = {2'b01, 2'b00};
        3'd5: o = {2'b11, 2'b01};
        3'd6: o = {2'b00, 2'b01};
        3'd7: o = {2'b01, 2'b01};
        default: o = 4'b0000;
      endcase
    end else begin
      unique case (k[1:0])
        2'd0: o = {2'b00, 2'b11};
        2'd1: o = {2'b00, 2'b01};
        2'd2: o = {2'b11, 2'b00};
        2'd3: o = {2'b01, 2'b00};
        default: o = 4'b0000;
      endcase
    end
    return o;
  endfunction

endpackage

### hdl/rpg_mul.sv
// Registered multiplier shared by the pick and threshold computations.
`timescale 1ns / 1ps
module rpg_mul import rpg_pkg::*; #(
  parameter int BW = 16
) (
  input  logic             clk,
  input  logic [15:0]      a,
  input  logic [BW-1:0]    b,
  output logic [BW+15:0]   p_r
);

  logic [BW+15:0] p_nxt;

  assign p_nxt = (BW + 16)'(a) * (BW + 16)'(b);

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

### hdl/raster_patch_growth_engine_top.sv
// Top level of the raster patch growth engine.
//
// Input items arrive on in_valid/in_stall with payload in_data; the block
// raises in_stall while it works on an item. Each item gives exactly one
// result on out_valid/out_stall with payload out_data, held until taken.
// Configuration is written on cfg_valid/cfg_ready, always ready, and is
// applied at once; write it only while no item is in work.
// A load result is offered in the cycle after its transfer. A grow step
// in random or circular mode picks a frontier entry with the multiplier
// and takes it; random mode then checks its neighbors, while circular mode
// regathers once the frontier is empty. Cost mode picks by a full pass and
// a partial pass over the frontier instead, each entry read through the
// single read ports of the frontier and weight memories. A gather visits
// every cell in use, reading neighbors of free cells from the grid memory.
// After reset the grid memory is swept to free, one cell per cycle over all
// 2**(clog2(MAX_ROWS)+clog2(MAX_COLS)) addresses, before the first transfer.
// A stalled result holds the block; no new item is taken until it leaves.
`timescale 1ns / 1ps
module raster_patch_growth_engine_top import rpg_pkg::*; #(
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int MAX_COLS    = DEF_MAX_COLS,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);

  localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW     = RW + CW;
  localparam int DEPTH  = 1 << AW;
  localparam int CNT_W  = AW + 1;
  localparam int CELLS  = MAX_ROWS * MAX_COLS;
  localparam int TOT_A  = WEIGHT_BITS + CNT_W;
  localparam int TOT_W  = (TOT_A > 17) ? TOT_A : 17;
  localparam int MB_A   = (TOT_W - 16 > CNT_W) ? TOT_W - 16 : CNT_W;
  localparam int MB     = (MB_A > 16) ? MB_A : 16;

  state_t state_r, state_nxt;

  logic [1:0]       grow_mode_r;
  logic             conn_r;
  logic [6:0]       grid_rows_r, grid_cols_r;
  in_item_t         req_r, req_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [AW-1:0]    pick_r, pick_nxt;
  logic [TOT_W-1:0] total_r, total_nxt, t_r, t_nxt, cum_r, cum_nxt;
  logic [2:0]       k_r, k_nxt;
  logic [DIM_W-1:0] base_row_r, base_row_nxt, base_col_r, base_col_nxt;
  logic [1:0]       status_r, status_nxt;
  logic             regath_r, regath_nxt;
  logic [5:0]       grow_row_r, grow_row_nxt, grow_col_r, grow_col_nxt;

  logic             patch_mem [DEPTH];
  logic [WEIGHT_BITS-1:0] weight_mem [DEPTH];
  logic [AW-1:0]    list_mem [DEPTH];
  logic [AW-1:0]    pos_mem [DEPTH];

  logic             patch_q, patch_we, patch_wd;
  logic [AW-1:0]    patch_wa, patch_ra;
  logic [WEIGHT_BITS-1:0] weight_q;
  logic             weight_we;
  logic [AW-1:0]    weight_wa, weight_ra;
  logic [AW-1:0]    list_q, list_wa, list_wd, list_ra;
  logic             list_we;
  logic [AW-1:0]    pos_q, pos_wa, pos_wd, pos_ra;
  logic             pos_we;

  logic [MB-1:0]    mul_b;
  logic [MB+15:0]   prod;

  logic             in_acc;
  logic [DIM_W-1:0] rows_used, cols_used;
  logic [3:0]       off;
  logic signed [DIM_W:0] nr, nc;
  logic             n_in, k_last, col_last, scan_last, can_push, listed_rng;
  logic             idx_last, load_ok;
  logic [AW-1:0]    n_addr, base_addr, load_addr;
  logic [CNT_W-1:0] cnt_m1;
  logic [TOT_W-1:0] cum_sum;
  logic [DIM_W-1:0] grow_row_ext, grow_col_ext;
  logic [31:0]      cnt_ext;

  rpg_mul #(.BW(MB)) u_mul (
    .clk (clk),
    .a   (req_r.random_fraction),
    .b   (mul_b),
    .p_r (prod)
  );

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign cfg_ready = 1'b1;

  always_comb begin
    if (grid_rows_r == 7'd0) begin
      rows_used = DIM_W'(1);
    end else if (DIM_W'(grid_rows_r) > DIM_W'(MAX_ROWS)) begin
      rows_used = DIM_W'(MAX_ROWS);
    end else begin
      rows_used = DIM_W'(grid_rows_r);
    end
    if (grid_cols_r == 7'd0) begin
      cols_used = DIM_W'(1);
    end else if (DIM_W'(grid_cols_r) > DIM_W'(MAX_COLS)) begin
      cols_used = DIM_W'(MAX_COLS);
    end else begin
      cols_used = DIM_W'(grid_cols_r);
    end
  end

  assign off        = nb_offset(conn_r, k_r);
  assign nr         = $signed({1'b0, base_row_r}) + (DIM_W + 1)'($signed(off[3:2]));
  assign nc         = $signed({1'b0, base_col_r}) + (DIM_W + 1)'($signed(off[1:0]));
  assign n_in       = (nr >= 0) && (nr < $signed({1'b0, rows_used})) &&
                      (nc >= 0) && (nc < $signed({1'b0, cols_used}));
  assign n_addr     = {nr[RW-1:0], nc[CW-1:0]};
  assign base_addr  = {base_row_r[RW-1:0], base_col_r[CW-1:0]};
  assign k_last     = conn_r ? (k_r == 3'd7) : (k_r == 3'd3);
  assign col_last   = (base_col_r + DIM_W'(1)) >= cols_used;
  assign scan_last  = col_last && ((base_row_r + DIM_W'(1)) >= rows_used);
  assign can_push   = cnt_r < CNT_W'(CELLS);
  assign listed_rng = {1'b0, pos_q} < cnt_r;
  assign idx_last   = ({1'b0, idx_r} + CNT_W'(1)) == cnt_r;
  assign cnt_m1     = cnt_r - CNT_W'(1);
  assign cum_sum    = cum_r + TOT_W'(weight_q);
  assign load_ok    = (DIM_W'(in_data.cell_row) < rows_used) &&
                      (DIM_W'(in_data.cell_col) < cols_used);
  assign grow_row_ext = DIM_W'(in_data.cell_row);
  assign grow_col_ext = DIM_W'(in_data.cell_col);
  assign load_addr  = {grow_row_ext[RW-1:0], grow_col_ext[CW-1:0]};
  assign cnt_ext    = 32'(cnt_r);

  assign out_data.status        = status_r;
  assign out_data.grown_row     = grow_row_r;
  assign out_data.grown_col     = grow_col_r;
  assign out_data.frontier_size = cnt_ext[12:0];
  assign out_data.regathered    = regath_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == {AW{1'b1}}) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.req_type == REQ_GROW) begin
            if (cnt_r == '0) begin
              state_nxt = ST_OUT;
            end else if (grow_mode_r == MODE_COST) begin
              state_nxt = ST_SUM_L;
            end else begin
              state_nxt = ST_PICK_MUL;
            end
          end else if (in_data.req_type == REQ_GATHER) begin
            state_nxt = ST_G_SELF;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_PICK_MUL: state_nxt = ST_PICK_SET;
      ST_PICK_SET: state_nxt = ST_TAKE;
      ST_SUM_L:    state_nxt = ST_SUM_W;
      ST_SUM_W:    state_nxt = ST_SUM_A;
      ST_SUM_A:    state_nxt = idx_last ? ST_SUM_DONE : ST_SUM_L;
      ST_SUM_DONE: state_nxt = (total_r == '0) ? ST_OUT : ST_T1;
      ST_T1:       state_nxt = ST_T2;
      ST_T2:       state_nxt = ST_CUM_L;
      ST_CUM_L:    state_nxt = ST_CUM_W;
      ST_CUM_W:    state_nxt = ST_CUM_A;
      ST_CUM_A:    state_nxt = ((cum_sum > t_r) || idx_last) ? ST_TAKE : ST_CUM_L;
      ST_TAKE:     state_nxt = ST_TAKE2;
      ST_TAKE2:    state_nxt = ST_TAKE3;
      ST_TAKE3: begin
        if (grow_mode_r == MODE_CIRC) begin
          state_nxt = (cnt_r == '0) ? ST_G_SELF : ST_OUT;
        end else begin
          state_nxt = ST_NB;
        end
      end
      ST_NB: begin
        if (n_in) begin
          state_nxt = ST_NB2;
        end else begin
          state_nxt = k_last ? ST_OUT : ST_NB;
        end
      end
      ST_NB2: begin
        if (!patch_q && listed_rng) begin
          state_nxt = ST_NB3;
        end else begin
          state_nxt = k_last ? ST_OUT : ST_NB;
        end
      end
      ST_NB3:     state_nxt = k_last ? ST_OUT : ST_NB;
      ST_G_SELF:  state_nxt = ST_G_SELF2;
      ST_G_SELF2: begin
        if (patch_q) begin
          state_nxt = scan_last ? ST_OUT : ST_G_SELF;
        end else begin
          state_nxt = ST_G_NB;
        end
      end
      ST_G_NB: begin
        if (n_in) begin
          state_nxt = ST_G_NB2;
        end else if (k_last) begin
          state_nxt = scan_last ? ST_OUT : ST_G_SELF;
        end else begin
          state_nxt = ST_G_NB;
        end
      end
      ST_G_NB2: begin
        if (patch_q || k_last) begin
          state_nxt = scan_last ? ST_OUT : ST_G_SELF;
        end else begin
          state_nxt = ST_G_NB;
        end
      end
      ST_OUT: if (!out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    req_nxt      = req_r;
    cnt_nxt      = cnt_r;
    clr_nxt      = clr_r;
    idx_nxt      = idx_r;
    pick_nxt     = pick_r;
    total_nxt    = total_r;
    t_nxt        = t_r;
    cum_nxt      = cum_r;
    k_nxt        = k_r;
    base_row_nxt = base_row_r;
    base_col_nxt = base_col_r;
    status_nxt   = status_r;
    regath_nxt   = regath_r;
    grow_row_nxt = grow_row_r;
    grow_col_nxt = grow_col_r;
    patch_we  = 1'b0;
    patch_wa  = load_addr;
    patch_wd  = in_data.patch_bit;
    patch_ra  = base_addr;
    weight_we = 1'b0;
    weight_wa = load_addr;
    weight_ra = list_q;
    list_we   = 1'b0;
    list_wa   = cnt_r[AW-1:0];
    list_wd   = n_addr;
    list_ra   = idx_r;
    pos_we    = 1'b0;
    pos_wa    = n_addr;
    pos_wd    = cnt_r[AW-1:0];
    pos_ra    = n_addr;
    mul_b     = MB'(cnt_r);
    unique case (state_r)
      ST_CLEAR: begin
        patch_we = 1'b1;
        patch_wa = clr_r;
        patch_wd = 1'b0;
        clr_nxt  = clr_r + AW'(1);
      end
      ST_IDLE: begin
        if (in_acc) begin
          req_nxt      = in_data;
          status_nxt   = STAT_OK;
          regath_nxt   = 1'b0;
          grow_row_nxt = '0;
          grow_col_nxt = '0;
          idx_nxt      = '0;
          total_nxt    = '0;
          base_row_nxt = '0;
          base_col_nxt = '0;
          if (in_data.req_type == REQ_LOAD && load_ok) begin
            patch_we  = 1'b1;
            weight_we = 1'b1;
          end
          if (in_data.req_type == REQ_GATHER) cnt_nxt = '0;
          if (in_data.req_type == REQ_GROW && cnt_r == '0) status_nxt = STAT_EMPTY;
        end
      end
      ST_PICK_MUL: mul_b = MB'(cnt_r);
      ST_PICK_SET: pick_nxt = prod[16 +: AW];
      ST_SUM_L:    list_ra = idx_r;
      ST_SUM_W:    weight_ra = list_q;
      ST_SUM_A: begin
        total_nxt = total_r + TOT_W'(weight_q);
        idx_nxt   = idx_r + AW'(1);
      end
      ST_SUM_DONE: begin
        mul_b = MB'(total_r >> 16);
        if (total_r == '0) begin
          cnt_nxt    = '0;
          status_nxt = STAT_ZERO;
        end
      end
      ST_T1: begin
        t_nxt = prod[TOT_W-1:0];
        mul_b = MB'(total_r[15:0]);
      end
      ST_T2: begin
        t_nxt   = t_r + TOT_W'(prod[31:16]);
        idx_nxt = '0;
        cum_nxt = '0;
      end
      ST_CUM_L: list_ra = idx_r;
      ST_CUM_W: weight_ra = list_q;
      ST_CUM_A: begin
        cum_nxt = cum_sum;
        if (cum_sum > t_r) begin
          pick_nxt = idx_r;
        end else if (idx_last) begin
          pick_nxt = cnt_m1[AW-1:0];
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      ST_TAKE: list_ra = pick_r;
      ST_TAKE2: begin
        base_row_nxt = DIM_W'(list_q[AW-1:CW]);
        base_col_nxt = DIM_W'(list_q[CW-1:0]);
        grow_row_nxt = 6'(list_q[AW-1:CW]);
        grow_col_nxt = 6'(list_q[CW-1:0]);
        patch_we     = 1'b1;
        patch_wa     = list_q;
        patch_wd     = 1'b1;
        cnt_nxt      = cnt_m1;
        list_ra      = cnt_m1[AW-1:0];
      end
      ST_TAKE3: begin
        list_we = 1'b1;
        list_wa = pick_r;
        list_wd = list_q;
        pos_we  = 1'b1;
        pos_wa  = list_q;
        pos_wd  = pick_r;
        k_nxt   = '0;
        if (grow_mode_r == MODE_CIRC && cnt_r == '0) begin
          regath_nxt   = 1'b1;
          base_row_nxt = '0;
          base_col_nxt = '0;
        end
      end
      ST_NB: begin
        patch_ra = n_addr;
        pos_ra   = n_addr;
        if (!n_in) k_nxt = k_r + 3'd1;
      end
      ST_NB2: begin
        list_ra = pos_q;
        if (!patch_q && listed_rng) begin
          k_nxt = k_r;
        end else begin
          k_nxt = k_r + 3'd1;
          if (!patch_q && can_push) begin
            list_we = 1'b1;
            pos_we  = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      ST_NB3: begin
        k_nxt = k_r + 3'd1;
        if (list_q != n_addr && can_push) begin
          list_we = 1'b1;
          pos_we  = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_G_SELF: patch_ra = base_addr;
      ST_G_SELF2: begin
        k_nxt = '0;
        if (patch_q) begin
          if (col_last) begin
            base_col_nxt = '0;
            base_row_nxt = base_row_r + DIM_W'(1);
          end else begin
            base_col_nxt = base_col_r + DIM_W'(1);
          end
        end
      end
      ST_G_NB: begin
        patch_ra = n_addr;
        if (!n_in) begin
          k_nxt = k_r + 3'd1;
          if (k_last) begin
            if (col_last) begin
              base_col_nxt = '0;
              base_row_nxt = base_row_r + DIM_W'(1);
            end else begin
              base_col_nxt = base_col_r + DIM_W'(1);
            end
          end
        end
      end
      ST_G_NB2: begin
        k_nxt = k_r + 3'd1;
        if (patch_q && can_push) begin
          list_we = 1'b1;
          list_wd = base_addr;
          pos_we  = 1'b1;
          pos_wa  = base_addr;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        if (patch_q || k_last) begin
          if (col_last) begin
            base_col_nxt = '0;
            base_row_nxt = base_row_r + DIM_W'(1);
          end else begin
            base_col_nxt = base_col_r + DIM_W'(1);
          end
        end
      end
      ST_OUT: begin
        k_nxt = k_r;
      end
      default: begin
        k_nxt = k_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (patch_we) patch_mem[patch_wa] <= patch_wd;
    patch_q <= patch_mem[patch_ra];
  end

  always_ff @(posedge clk) begin
    if (weight_we) weight_mem[weight_wa] <= WEIGHT_BITS'(in_data.cell_weight);
    weight_q <= weight_mem[weight_ra];
  end

  always_ff @(posedge clk) begin
    if (list_we) list_mem[list_wa] <= list_wd;
    list_q <= list_mem[list_ra];
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    pos_q <= pos_mem[pos_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      grow_mode_r <= MODE_RANDOM;
      conn_r      <= 1'b0;
      grid_rows_r <= 7'd64;
      grid_cols_r <= 7'd64;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_GROW_MODE:    grow_mode_r <= cfg_data[1:0];
          CFG_CONNECTIVITY: conn_r      <= cfg_data[0];
          CFG_GRID_ROWS:    grid_rows_r <= cfg_data;
          CFG_GRID_COLS:    grid_cols_r <= cfg_data;
          default:          grow_mode_r <= grow_mode_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    idx_r      <= idx_nxt;
    pick_r     <= pick_nxt;
    total_r    <= total_nxt;
    t_r        <= t_nxt;
    cum_r      <= cum_nxt;
    k_r        <= k_nxt;
    base_row_r <= base_row_nxt;
    base_col_r <= base_col_nxt;
    status_r   <= status_nxt;
    regath_r   <= regath_nxt;
    grow_row_r <= grow_row_nxt;
    grow_col_r <= grow_col_nxt;
  end

endmodule
